[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fut_pkg.sv]
// ----------------------------------------------------------------------------
// fut_pkg
// types, character codes and helpers for the form-urlencoded tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package fut_pkg;

  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_PAIR_END  = 3'd2,
    KIND_NAME_ONLY = 3'd3,
    KIND_DONE_OK   = 3'd4,
    KIND_DONE_ERR  = 3'd5
  } kind_t;

  localparam int unsigned MAX_RES = 4;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CASE_MASK = 8'hdf;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
  } res_ent_t;

  typedef struct packed {
    logic [2:0]           cnt;
    res_ent_t [MAX_RES-1:0] ent;
  } res_list_t;

  // loose hex digit, wraps modulo 256
  function automatic logic [7:0] hex_digit(logic [7:0] c);
    if (c >= CH_UA) begin
      return ((c & CASE_MASK) - CH_UA) + HEX_TEN;
    end
    return c - CH_ZERO;
  endfunction

  // append one result, results beyond the list size are dropped
  function automatic res_list_t push(res_list_t l, kind_t k, logic [7:0] b);
    res_list_t r;
    r = l;
    if (r.cnt < 3'(MAX_RES)) begin
      r.ent[r.cnt[1:0]] = '{kind: k, out_byte: b};
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/form_urlencoded_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// form_urlencoded_tokenizer_unit
// streaming tokenizer for form-urlencoded query strings
// ----------------------------------------------------------------------------
// Takes one raw query-string byte per word, the final byte of a string
// flagged by end_of_input, and returns tagged name and value bytes ('+' as
// space, %XY decoded with the loose hex rule), pair-end and name-only markers,
// and one done-ok or done-error status per string. Every input word is parsed
// in the cycle it is accepted and its results (zero to four) are written into
// a four-entry result buffer that drains one word per cycle on the out port
// while out_ready is high. A byte that yields several results holds the input
// until the single result port has emptied the buffer. The next byte is taken
// in the same cycle the last buffered result leaves, so there is no bubble
// between bytes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module form_urlencoded_tokenizer_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fut_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fut_pkg::out_word_t     out_data
);
  import fut_pkg::*;

  typedef enum logic [1:0] {
    MODE_SKIP  = 2'd0,  // skipping delimiters before a name
    MODE_NAME  = 2'd1,
    MODE_VALUE = 2'd2,
    MODE_DRAIN = 2'd3   // ignoring bytes after an error
  } mode_t;

  // parser state
  mode_t      mode_r,  mode_nxt;
  logic [1:0] esc_r,   esc_nxt;     // 0 none, 1 after '%', 2 after first hex char
  logic [7:0] fhex_r,  fhex_nxt;
  logic       thb_r,   thb_nxt;     // token has emitted bytes
  logic       cut_r,   cut_nxt;     // token cut by a zero byte
  logic       kept_r,  kept_nxt;    // value belongs to a non-empty name

  // result buffer
  res_ent_t [MAX_RES-1:0] ent_r;
  logic [2:0]             cnt_r;
  logic [1:0]             idx_r;
  res_list_t              lst;

  logic in_fire, out_fire, at_last;

  assign at_last   = (({1'b0, idx_r} + 3'd1) == cnt_r);
  assign out_valid = (cnt_r != 3'd0);
  assign out_fire  = out_valid && out_ready;
  // take a new byte once the buffer is empty or its last word leaves now
  assign in_ready  = (cnt_r == 3'd0) || (at_last && out_ready);
  assign in_fire   = in_valid && in_ready;

  assign out_data.kind     = ent_r[idx_r].kind;
  assign out_data.out_byte = ent_r[idx_r].out_byte;
  assign out_data.run_last = at_last;

  // single-pass parse of one byte
  always_comb begin
    logic [7:0] c;
    logic [7:0] v;
    logic [7:0] hi;
    logic       e;
    logic       delim;
    logic       allowed;
    kind_t      tk;
    mode_t      pm;

    c        = in_data.in_byte;
    e        = in_data.end_of_input;
    delim    = (c == CH_EQ) || (c == CH_AMP);
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    fhex_nxt = fhex_r;
    thb_nxt  = thb_r;
    cut_nxt  = cut_r;
    kept_nxt = kept_r;
    lst      = '0;
    v        = '0;
    hi       = '0;
    pm       = mode_r;
    tk       = KIND_NAME;
    allowed  = 1'b0;

    if (mode_r == MODE_DRAIN) begin
      if (e) begin
        mode_nxt = MODE_SKIP;
        kept_nxt = 1'b0;
        esc_nxt  = 2'd0;
        fhex_nxt = '0;
        thb_nxt  = 1'b0;
        cut_nxt  = 1'b0;
      end
    end else begin
      // leading delimiters
      if (mode_nxt == MODE_SKIP) begin
        if (delim) begin
          if (e) begin
            lst = push(lst, KIND_DONE_ERR, 8'd0);
          end
        end else begin
          mode_nxt = MODE_NAME;
        end
      end

      pm      = mode_nxt;
      tk      = (pm == MODE_VALUE) ? KIND_VALUE : KIND_NAME;
      allowed = (pm == MODE_NAME) || kept_nxt;

      if (pm == MODE_NAME || pm == MODE_VALUE) begin
        // token character
        if (!delim) begin
          if (c == CH_PLUS) begin
            c = CH_SPACE;
          end
          if (c == 8'd0) begin
            cut_nxt = 1'b1;
            esc_nxt = 2'd0;
          end else if (esc_nxt == 2'd1) begin
            fhex_nxt = c;
            esc_nxt  = 2'd2;
          end else if (esc_nxt == 2'd2) begin
            hi      = hex_digit(fhex_nxt);
            v       = {hi[3:0], 4'b0000} + hex_digit(c);
            esc_nxt = 2'd0;
            if (v == 8'd0) begin
              cut_nxt = 1'b1;
            end else if (!cut_nxt && allowed) begin
              lst     = push(lst, tk, v);
              thb_nxt = 1'b1;
            end
          end else if (c == CH_PCT) begin
            esc_nxt = 2'd1;
          end else if (!cut_nxt && allowed) begin
            lst     = push(lst, tk, c);
            thb_nxt = 1'b1;
          end
        end

        // end of token: a pending escape goes out literally
        if (delim || e) begin
          if (esc_nxt != 2'd0) begin
            if (!cut_nxt && allowed) begin
              lst     = push(lst, tk, CH_PCT);
              thb_nxt = 1'b1;
            end
            if (esc_nxt == 2'd2 && !cut_nxt && allowed) begin
              lst     = push(lst, tk, fhex_nxt);
              thb_nxt = 1'b1;
            end
          end
          esc_nxt  = 2'd0;
          fhex_nxt = '0;
        end

        if (pm == MODE_NAME) begin
          if (c == CH_EQ && !e) begin
            kept_nxt = thb_nxt;
            thb_nxt  = 1'b0;
            cut_nxt  = 1'b0;
            mode_nxt = MODE_VALUE;
          end else if (delim || e) begin
            if (thb_nxt) begin
              lst = push(lst, KIND_NAME_ONLY, 8'd0);
            end
            if (c == CH_AMP && !e) begin
              // '&' after a name that is not last
              lst      = push(lst, KIND_DONE_ERR, 8'd0);
              mode_nxt = MODE_DRAIN;
            end else if (delim) begin
              lst      = push(lst, KIND_DONE_OK, 8'd0);
              mode_nxt = MODE_SKIP;
            end else begin
              // name ran to the end
              lst      = push(lst, KIND_DONE_ERR, 8'd0);
              mode_nxt = MODE_SKIP;
            end
            kept_nxt = 1'b0;
            thb_nxt  = 1'b0;
            cut_nxt  = 1'b0;
          end
        end else begin
          if (delim || e) begin
            if (kept_nxt) begin
              lst = push(lst, KIND_PAIR_END, 8'd0);
            end
            if (e) begin
              lst = push(lst, KIND_DONE_OK, 8'd0);
            end
            kept_nxt = 1'b0;
            thb_nxt  = 1'b0;
            cut_nxt  = 1'b0;
            mode_nxt = MODE_SKIP;
          end
        end
      end else if (e) begin
        // skip ran into the final byte: back to reset
        kept_nxt = 1'b0;
        esc_nxt  = 2'd0;
        fhex_nxt = '0;
        thb_nxt  = 1'b0;
        cut_nxt  = 1'b0;
      end
    end
  end

  // state and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
      esc_r  <= 2'd0;
      fhex_r <= '0;
      thb_r  <= 1'b0;
      cut_r  <= 1'b0;
      kept_r <= 1'b0;
      cnt_r  <= 3'd0;
      idx_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        // a new byte refills the buffer, its last old word leaves now
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
        fhex_r <= fhex_nxt;
        thb_r  <= thb_nxt;
        cut_r  <= cut_nxt;
        kept_r <= kept_nxt;
        cnt_r  <= lst.cnt;
        idx_r  <= 2'd0;
      end else if (out_fire) begin
        if (at_last) begin
          cnt_r <= 3'd0;
          idx_r <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  // payload of the buffer, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ent_r <= lst.ent;
    end
  end

  `ASSERT_NOW(a_idx_in_range, clk, rst_n, out_valid, ({1'b0, idx_r} < cnt_r),
    "read index past buffer fill")
  `ASSERT_NEXT(a_drain_silent, clk, rst_n,
    in_fire && mode_r == MODE_DRAIN && !in_data.end_of_input, !out_valid,
    "result produced while draining")
  `ASSERT_NEXT(a_end_resets, clk, rst_n, in_fire && in_data.end_of_input,
    mode_r == MODE_SKIP && !kept_r && esc_r == 2'd0,
    "parser not back at reset after final byte")
  `ASSERT_NEXT(a_end_has_status, clk, rst_n,
    in_fire && in_data.end_of_input && mode_r != MODE_DRAIN,
    out_valid && (ent_r[cnt_r[1:0] - 2'd1].kind == KIND_DONE_OK ||
                  ent_r[cnt_r[1:0] - 2'd1].kind == KIND_DONE_ERR),
    "final byte did not end with a status")

endmodule

`default_nettype wire
